FILE: src/min_tracking_stack_assert.svh
// Assertion macros used by the min tracking stack datapath.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

`ifndef SYNTHESIS
`define MTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define MTS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define MTS_ASSERT(lbl, prop, msg)
`define MTS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: src/mts_pkg.sv
// Shared types and codes of the min tracking stack.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mts_pkg;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] popped;
        logic [3:0]         count;
        logic signed [31:0] minimum;
        logic               minimum_valid;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

FILE: src/mts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mts_ctrl.sv
// Sequencing controller of the min tracking stack.
// Depends on mts_pkg for the command and status structs.
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  mts_pkg::t_stat i_stat,
    output mts_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_FETCH = 4'b0100,
        S_LOAD  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FETCH;
            end
            // The minimum store is read again at the updated count here.
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/mts_dp.sv
// Datapath of the min tracking stack: counters, both stores and the output register.
// Depends on mts_pkg, mts_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "min_tracking_stack_assert.svh"

module mts_dp #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mts_pkg::t_in_beat  i_in,
    input  mts_pkg::t_cmd      i_cmd,
    output mts_pkg::t_stat     o_stat,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output mts_pkg::t_out_beat o_out
);

    localparam int CountBits = $clog2(DEPTH + 1);
    localparam int AddrBits  = $clog2(DEPTH);
    localparam logic [CountBits-1:0] Full = CountBits'(DEPTH);

    logic [CountBits-1:0] r_main_count, n_main_count;
    logic [CountBits-1:0] r_min_count, n_min_count;
    logic                 r_kind;
    logic [WORD_BITS-1:0] r_value;
    mts_pkg::t_status     r_status, n_status;
    logic [WORD_BITS-1:0] r_popped, n_popped;
    logic                 r_out_valid;
    mts_pkg::t_out_beat   r_out, n_out;

    logic                 main_we, min_we, push_min;
    logic [WORD_BITS-1:0] main_top, min_top;

    // Both stores are read at their top every cycle; the read data is registered.
    mts_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_we),
        .i_waddr (AddrBits'(r_main_count)),
        .i_wdata (r_value),
        .i_raddr (AddrBits'(r_main_count - 1'b1)),
        .o_rdata (main_top)
    );

    mts_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (AddrBits'(r_min_count)),
        .i_wdata (r_value),
        .i_raddr (AddrBits'(r_min_count - 1'b1)),
        .o_rdata (min_top)
    );

    assign push_min = (r_min_count == '0) || ($signed(r_value) <= $signed(min_top));

    always_comb begin
        n_main_count = r_main_count;
        n_min_count  = r_min_count;
        n_status     = r_status;
        n_popped     = r_popped;
        main_we      = 1'b0;
        min_we       = 1'b0;
        if (i_cmd.exec) begin
            n_status = mts_pkg::ST_DONE;
            n_popped = '0;
            if (r_kind == mts_pkg::KIND_PUSH) begin
                if (r_main_count == Full) begin
                    n_status = mts_pkg::ST_FULL;
                end else begin
                    main_we      = 1'b1;
                    n_main_count = r_main_count + 1'b1;
                    if (push_min && (r_min_count != Full)) begin
                        min_we      = 1'b1;
                        n_min_count = r_min_count + 1'b1;
                    end
                end
            end else begin
                if (r_main_count == '0) begin
                    n_status = mts_pkg::ST_EMPTY;
                end else begin
                    if ((r_min_count != '0) && (min_top == main_top)) begin
                        n_min_count = r_min_count - 1'b1;
                    end
                    n_main_count = r_main_count - 1'b1;
                    n_popped     = main_top;
                end
            end
        end
    end

    // Outputs carry the low 32 bits of a stored word, zero filled when the word is narrower.
    always_comb begin
        n_out.status        = r_status;
        n_out.popped        = 32'($unsigned(r_popped));
        n_out.count         = 4'(r_main_count);
        n_out.minimum_valid = (r_main_count != '0);
        if ((r_min_count != '0) && (r_main_count != '0)) begin
            n_out.minimum = 32'($unsigned(min_top));
        end else begin
            n_out.minimum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_count <= '0;
            r_min_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_main_count <= n_main_count;
            r_min_count  <= n_min_count;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_in.kind;
            r_value <= WORD_BITS'(i_in.value);
        end
        r_status <= n_status;
        r_popped <= n_popped;
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    `MTS_ASSERT_NEVER(a_count_bound, r_main_count > Full, "main count above depth")
    `MTS_ASSERT_NEVER(a_min_not_deeper, r_min_count > r_main_count, "minimum stack deeper than main")
    `MTS_ASSERT(a_pop_shrinks, i_cmd.exec && (r_kind == mts_pkg::KIND_POP) && (r_main_count != '0) |=> r_main_count == CountBits'($past(r_main_count) - 1'b1), "pop did not shrink stack")
    `MTS_ASSERT(a_push_grows, i_cmd.exec && (r_kind == mts_pkg::KIND_PUSH) && (r_main_count != Full) |=> r_main_count == CountBits'($past(r_main_count) + 1'b1), "push did not grow stack")

endmodule

FILE: src/min_tracking_stack.sv
// Top level of the min tracking stack: controller and datapath joined by command structs.
// Depends on mts_pkg, mts_ctrl and mts_dp.
//
//  Channel  Direction  Handshake                 Beat
//  in       to block   i_in_valid / o_in_stall   mts_pkg::t_in_beat  (kind, value)
//  out      from block o_out_valid / i_out_stall mts_pkg::t_out_beat (status, popped, count,
//                                                minimum, minimum_valid)
//
// Each beat passes through these steps in order: accept, execute against the store tops,
// re-read the minimum store at its new top, and load the output register. The registered
// read of the minimum store after its update is what makes the re-read step necessary.
// The next input beat is taken while a result still waits in the output register.
// Reset is synchronous and active low; it empties both stacks at once.
// A stalled output holds the controller in its load step until the register frees.
`timescale 1ns / 1ps

module min_tracking_stack #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mts_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mts_pkg::t_out_beat o_out
);

    mts_pkg::t_cmd  cmd;
    mts_pkg::t_stat stat;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mts_dp #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
